@@ hdl/cfb_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the command frame builder.
// No dependencies; used by every module of the block.
package cfb_pkg;

  localparam int MAX_DATA_BYTES = 32;
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] ADDR_RESET = 16'hFE00;
  localparam logic [7:0] COUNT_OFFSET = 8'd9;
  localparam logic [7:0] MAX_COUNT = 8'(MAX_DATA_BYTES);

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [3:0] STEP_ADDR_HI = 4'd0;
  localparam logic [3:0] STEP_ADDR_LO = 4'd1;
  localparam logic [3:0] STEP_COUNT = 4'd2;
  localparam logic [3:0] STEP_OPCODE = 4'd3;
  localparam logic [3:0] STEP_MODE = 4'd4;
  localparam logic [3:0] STEP_P1_HI = 4'd5;
  localparam logic [3:0] STEP_P1_LO = 4'd6;
  localparam logic [3:0] STEP_P2_HI = 4'd7;
  localparam logic [3:0] STEP_P2_LO = 4'd8;
  localparam logic [3:0] STEP_CRC_HI = 4'd9;
  localparam logic [3:0] STEP_CRC_LO = 4'd10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  opcode;
    logic [7:0]  command_mode;
    logic [15:0] first_param;
    logic [15:0] second_param;
    logic [5:0]  data_count;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       out_of_frame;
  } word_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/command_frame_builder_crc16_top.sv @@
// Top level of the command frame builder with CRC-16 (poly 0x8005, init 0).
// Depends on cfb_pkg, cfb_seq and cfb_out_reg.
//
// Each accepted item yields one frame word per clock unless stalled: a header gives
// 9 words, or 11 when its data count is zero; a data item gives 1 word, or 3 when
// it closes the frame. The next item is taken in the cycle its predecessor's last
// word moves into the output register, so a run of data items flows at one item per
// clock unless stalled. The sequencer's single word-per-cycle path and its one-byte
// CRC step set this rate. The sequencer reads the command address register as each
// header's address words go out; write it only while no item is in flight.
module command_frame_builder_crc16_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  opcode,
  input  logic [7:0]  command_mode,
  input  logic [15:0] first_param,
  input  logic [15:0] second_param,
  input  logic [5:0]  data_count,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        run_last,
  output logic        out_of_frame
);

  logic [15:0]    command_address;
  cfb_pkg::item_t item;
  cfb_pkg::word_t word;
  cfb_pkg::word_t out_word;
  logic           word_valid;
  logic           word_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_address <= cfb_pkg::ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      command_address <= cfg_data;
    end
  end

  always_comb begin
    item.kind = mode;
    item.opcode = opcode;
    item.command_mode = command_mode;
    item.first_param = first_param;
    item.second_param = second_param;
    item.data_count = data_count;
    item.data_byte = data_byte;
  end

  cfb_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .command_address (command_address),
    .item_valid_in   (in_valid),
    .item_stall      (in_stall),
    .item_in         (item),
    .word_valid      (word_valid),
    .word_ready      (word_ready),
    .word            (word)
  );

  cfb_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  assign out_byte = out_word.out_byte;
  assign frame_end = out_word.frame_end;
  assign run_last = out_word.run_last;
  assign out_of_frame = out_word.out_of_frame;

endmodule

@@ hdl/cfb_seq.sv @@
// Item register and frame sequencer: emits one frame word per cycle while word_ready
// is high and keeps the CRC. Depends on cfb_pkg.
module cfb_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        command_address,
  input  logic               item_valid_in,
  output logic               item_stall,
  input  cfb_pkg::item_t     item_in,
  output logic               word_valid,
  input  logic               word_ready,
  output cfb_pkg::word_t     word
);

  cfb_pkg::item_t item;
  cfb_pkg::item_t item_sat;
  logic           busy;
  logic [3:0]     step;
  logic [3:0]     step_next;
  logic [15:0]    running_crc;
  logic [5:0]     bytes_remaining;
  logic           frame_open;
  logic [5:0]     n_sat;
  logic           emit;
  logic           accept;
  logic           last;
  logic           data_ok;
  logic [7:0]     body_byte;

  always_comb begin
    if ({2'b00, item_in.data_count} > cfb_pkg::MAX_COUNT) begin
      n_sat = cfb_pkg::MAX_COUNT[5:0];
    end else begin
      n_sat = item_in.data_count;
    end
  end

  always_comb begin
    item_sat = item_in;
    item_sat.data_count = n_sat;
  end

  assign data_ok = frame_open && (bytes_remaining != 6'd0);
  assign emit = busy && word_ready;

  always_comb begin
    body_byte = 8'h00;
    case (step)
      cfb_pkg::STEP_ADDR_HI: body_byte = command_address[15:8];
      cfb_pkg::STEP_ADDR_LO: body_byte = command_address[7:0];
      cfb_pkg::STEP_COUNT:   body_byte = {2'b00, item.data_count} + cfb_pkg::COUNT_OFFSET;
      cfb_pkg::STEP_OPCODE:  body_byte = item.opcode;
      cfb_pkg::STEP_MODE:    body_byte = item.command_mode;
      cfb_pkg::STEP_P1_HI:   body_byte = item.first_param[15:8];
      cfb_pkg::STEP_P1_LO:   body_byte = item.first_param[7:0];
      cfb_pkg::STEP_P2_HI:   body_byte = item.second_param[15:8];
      cfb_pkg::STEP_P2_LO:   body_byte = item.second_param[7:0];
      cfb_pkg::STEP_CRC_HI:  body_byte = running_crc[15:8];
      cfb_pkg::STEP_CRC_LO:  body_byte = running_crc[7:0];
      default:               body_byte = 8'h00;
    endcase
  end

  always_comb begin
    word = '0;
    last = 1'b0;
    step_next = step + 4'd1;
    if (step == cfb_pkg::STEP_CRC_LO) begin
      word.out_byte = body_byte;
      word.frame_end = 1'b1;
      last = 1'b1;
    end else if (step == cfb_pkg::STEP_CRC_HI) begin
      word.out_byte = body_byte;
    end else if (item.kind == cfb_pkg::KIND_DATA) begin
      step_next = cfb_pkg::STEP_CRC_HI;
      if (data_ok) begin
        word.out_byte = item.data_byte;
        last = (bytes_remaining != 6'd1);
      end else begin
        word.out_of_frame = 1'b1;
        last = 1'b1;
      end
    end else begin
      word.out_byte = body_byte;
      if (step == cfb_pkg::STEP_P2_LO) begin
        last = (item.data_count != 6'd0);
      end
    end
    word.run_last = last;
  end

  assign word_valid = busy;
  assign item_stall = busy && !(emit && last);
  assign accept = item_valid_in && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= cfb_pkg::STEP_ADDR_HI;
    end else if (accept) begin
      busy <= 1'b1;
      step <= cfb_pkg::STEP_ADDR_HI;
    end else if (emit && last) begin
      busy <= 1'b0;
    end else if (emit) begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= 16'h0000;
      bytes_remaining <= 6'd0;
      frame_open <= 1'b0;
    end else if (emit) begin
      if (step == cfb_pkg::STEP_CRC_LO) begin
        frame_open <= 1'b0;
        bytes_remaining <= 6'd0;
      end else if (step == cfb_pkg::STEP_CRC_HI) begin
        frame_open <= frame_open;
      end else if (item.kind == cfb_pkg::KIND_DATA) begin
        if (data_ok) begin
          running_crc <= cfb_pkg::crc_byte(running_crc, item.data_byte);
          bytes_remaining <= bytes_remaining - 6'd1;
        end
      end else if (step == cfb_pkg::STEP_ADDR_HI) begin
        running_crc <= 16'h0000;
        bytes_remaining <= item.data_count;
        frame_open <= 1'b1;
      end else if (step != cfb_pkg::STEP_ADDR_LO) begin
        running_crc <= cfb_pkg::crc_byte(running_crc, body_byte);
      end
    end
  end

endmodule

@@ hdl/cfb_out_reg.sv @@
// Output register for frame words; passes downstream stall back to the sequencer as word_ready.
// Depends on cfb_pkg.
module cfb_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           word_valid,
  output logic           word_ready,
  input  cfb_pkg::word_t word,
  output logic           out_valid,
  input  logic           out_stall,
  output cfb_pkg::word_t out_word
);

  assign word_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word_ready) begin
      out_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) begin
      out_word <= word;
    end
  end

endmodule
